// ----- design/gda_pkg.sv -----
// Shared types, constants and calendar functions of the Gregorian date calculator.
// Used by gda_div, gda_dp, gda_ctrl and gregorian_date_arith; depends on nothing else.
package gda_pkg;

    // Largest valid year; valid years run from 0 to YEAR_MAX
    localparam int YEAR_MAX = 9999;

    // Field widths of the transactions
    localparam int OP_W    = 2;
    localparam int YEAR_FW = 14;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 16;
    localparam int CODE_W  = 2;

    // Calendar constants
    localparam int CENTURY       = 100;
    localparam int DAYS_PER_YEAR = 365;
    localparam int MONTHS        = 12;
    localparam int DOY_W         = 9;

    // Days from year 0 to the first day of year y
    function automatic int days_before_year(input int y);
        return DAYS_PER_YEAR * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    // Internal year width holds YEAR_MAX + 1 and the full input field
    localparam int YR_W   = ($clog2(YEAR_MAX + 2) > YEAR_FW) ? $clog2(YEAR_MAX + 2) : YEAR_FW;
    // Serial day numbers stay below the first day after YEAR_MAX
    localparam int SER_LIMIT = days_before_year(YEAR_MAX + 1);
    localparam int SER_W  = $clog2(SER_LIMIT);
    // Remainder of a division by one century
    localparam int REM_W  = $clog2(CENTURY);
    // Days still to walk: day - 1 + day_count
    localparam int RD_W   = CNT_W + 1;

    // Divide by one century as a multiply by a scaled reciprocal and a shift;
    // exact for every year of up to 18 bits
    localparam int C100_SHIFT   = 25;
    localparam int C100_RECIP   = (1 << C100_SHIFT) / CENTURY + 1;
    localparam int C100_RECIP_W = $clog2(C100_RECIP + 1);

    // Operations
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 2'd1;
    localparam logic [OP_W-1:0] OP_DIFF = 2'd2;
    localparam logic [OP_W-1:0] OP_CMP  = 2'd3;

    // Error codes
    localparam logic [CODE_W-1:0] ERR_OK    = 2'd0;
    localparam logic [CODE_W-1:0] ERR_DATE  = 2'd1;
    localparam logic [CODE_W-1:0] ERR_RANGE = 2'd2;
    localparam logic [CODE_W-1:0] ERR_SAT   = 2'd3;

    // Order codes
    localparam logic [CODE_W-1:0] ORD_BEFORE = 2'd0;
    localparam logic [CODE_W-1:0] ORD_EQUAL  = 2'd1;
    localparam logic [CODE_W-1:0] ORD_AFTER  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;
        logic              start;
        logic              sel_other;
        logic              step_init;
        logic              step;
        logic              ser_year;
        logic              ser_day;
        logic              fin;
        logic [CODE_W-1:0] err;
    } gda_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_busy;
        logic date_ok;
        logic date_op;
        logic step_done;
        logic step_ovf;
    } gda_sts_t;

    // Leap year from the low year bits, year mod 100 and (year / 100) mod 4
    function automatic logic leap_of(input logic [1:0] ylo, input logic [REM_W-1:0] m100,
                                     input logic [1:0] c4);
        return (ylo == 2'd0) && ((m100 != '0) || (c4 == 2'd0));
    endfunction

    // Length of a month, zero for a month code that means nothing
    function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
                                                       input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of a common year before the first day of month m
    function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] cum;
        case (m)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

// ----- design/gda_div.sv -----
// Division of a year by one century through a reciprocal multiply.
// Depends on gda_pkg; registers the product on start, then quotient and remainder.
module gda_div
    import gda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [YR_W-1:0]  dividend,
    output logic             busy,
    output logic [YR_W-1:0]  quot,
    output logic [REM_W-1:0] rem
);

    localparam int PROD_W = YR_W + C100_RECIP_W;

    logic [PROD_W-1:0] prod_reg;
    logic [YR_W-1:0]   dvd_reg;
    logic [YR_W-1:0]   quot_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              pend_reg;
    logic [YR_W-1:0]   q_est;

    // Take the quotient from the upper product bits
    always_comb
    begin
        q_est = YR_W'(prod_reg >> C100_SHIFT);
    end

    // Flag the cycle in which the product is ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= start;
        end
    end

    // Multiply on start, then split into quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(dividend) * PROD_W'(C100_RECIP);
            dvd_reg  <= dividend;
        end
        if (pend_reg)
        begin
            quot_reg <= q_est;
            rem_reg  <= REM_W'(dvd_reg - q_est * YR_W'(CENTURY));
        end
    end

    assign busy = pend_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/gda_dp.sv -----
// Datapath of the date calculator: input holding, date check, serial day numbers,
// month stepping and the result registers. Depends on gda_pkg and gda_div.
module gda_dp
    import gda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  gda_cmd_t           cmd,
    output gda_sts_t           sts,
    input  logic [OP_W-1:0]    operation,
    input  logic [YEAR_FW-1:0] base_year,
    input  logic [MON_W-1:0]   base_month,
    input  logic [DAY_W-1:0]   base_day,
    input  logic [CNT_W-1:0]   day_count,
    input  logic [YEAR_FW-1:0] other_year,
    input  logic [MON_W-1:0]   other_month,
    input  logic [DAY_W-1:0]   other_day,
    output logic [YEAR_FW-1:0] result_year,
    output logic [MON_W-1:0]   result_month,
    output logic [DAY_W-1:0]   result_day,
    output logic [CNT_W-1:0]   days_between,
    output logic [CODE_W-1:0]  order,
    output logic [CODE_W-1:0]  error_code
);

    // Held transaction
    logic [OP_W-1:0]    op_reg;
    logic [YEAR_FW-1:0] by_reg, oy_reg;
    logic [MON_W-1:0]   bm_reg, om_reg;
    logic [DAY_W-1:0]   bd_reg, od_reg;
    logic [CNT_W-1:0]   n_reg;

    // Date under work
    logic [YR_W-1:0]    year_reg;
    logic [MON_W-1:0]   month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [RD_W-1:0]    rd_reg;
    logic [REM_W-1:0]   m100_reg;
    logic [1:0]         c4_reg;

    // Serial day numbers
    logic [SER_W-1:0]   sery_reg, ser_a_reg, ser_b_reg;

    // Result registers
    logic [YEAR_FW-1:0] ry_reg;
    logic [MON_W-1:0]   rm_reg;
    logic [DAY_W-1:0]   rday_reg;
    logic [CNT_W-1:0]   between_reg;
    logic [CODE_W-1:0]  ord_reg, err_reg;

    // Divider interface
    logic [YR_W-1:0]    div_in, quot;
    logic [REM_W-1:0]   rem;
    logic               div_busy;

    logic               add_op, date_op, leap_div, leap_cur;
    logic [DAY_W-1:0]   len_chk, len_cur, len_prev;
    logic               step_done, step_ovf, date_ok;
    logic [SER_W-1:0]   y_s, c100, ser_y, ser_d;
    logic [SER_W-1:0]   diff;
    logic               sat, fin_ok;
    logic [CODE_W-1:0]  fin_err, fin_ord;

    assign div_in = cmd.sel_other ? YR_W'(oy_reg) : YR_W'(by_reg);

    gda_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .dividend (div_in),
        .busy     (div_busy),
        .quot     (quot),
        .rem      (rem)
    );

    // Check the date under work once the century split is known
    always_comb
    begin
        add_op   = op_reg == OP_ADD;
        date_op  = (op_reg == OP_ADD) || (op_reg == OP_SUB);
        leap_div = leap_of(year_reg[1:0], rem, quot[1:0]);
        len_chk  = days_in_month(leap_div, month_reg);
        date_ok  = (year_reg <= YR_W'(YEAR_MAX)) && (month_reg inside {[4'd1:4'd12]}) &&
                   (day_reg != '0) && (day_reg <= len_chk);
    end

    // Decide one month step
    always_comb
    begin
        leap_cur = leap_of(year_reg[1:0], m100_reg, c4_reg);
        len_cur  = days_in_month(leap_cur, month_reg);
        len_prev = days_in_month(leap_cur, month_reg - MON_W'(1));
        if (add_op)
        begin
            step_done = rd_reg < RD_W'(len_cur);
            step_ovf  = !step_done && (month_reg == MON_W'(MONTHS)) &&
                        (year_reg == YR_W'(YEAR_MAX));
        end
        else
        begin
            step_done = rd_reg < RD_W'(day_reg);
            step_ovf  = !step_done && (month_reg == MON_W'(1)) && (year_reg == '0);
        end
    end

    // Build serial day numbers: year part, then day of year
    always_comb
    begin
        y_s   = SER_W'(year_reg);
        c100  = SER_W'(quot) + SER_W'(rem != '0);
        ser_y = y_s * SER_W'(DAYS_PER_YEAR) + ((y_s + SER_W'(3)) >> 2) - c100 +
                ((c100 + SER_W'(3)) >> 2);
        ser_d = sery_reg + SER_W'(cum_days(month_reg)) +
                SER_W'(leap_div && (month_reg > MON_W'(2))) + SER_W'(day_reg) - SER_W'(1);
    end

    // Form the final difference, order and error code
    always_comb
    begin
        diff    = (ser_a_reg >= ser_b_reg) ? ser_a_reg - ser_b_reg : ser_b_reg - ser_a_reg;
        sat     = (diff >> CNT_W) != '0;
        fin_ok  = cmd.err == ERR_OK;
        fin_err = cmd.err;
        if (fin_ok && (op_reg == OP_DIFF) && sat)
        begin
            fin_err = ERR_SAT;
        end
        if (ser_a_reg < ser_b_reg)
        begin
            fin_ord = ORD_BEFORE;
        end
        else if (ser_a_reg == ser_b_reg)
        begin
            fin_ord = ORD_EQUAL;
        end
        else
        begin
            fin_ord = ORD_AFTER;
        end
    end

    // Hold the transaction fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            by_reg <= base_year;
            bm_reg <= base_month;
            bd_reg <= base_day;
            n_reg  <= day_count;
            oy_reg <= other_year;
            om_reg <= other_month;
            od_reg <= other_day;
        end
    end

    // Load, walk and finish the date under work
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            year_reg  <= div_in;
            month_reg <= cmd.sel_other ? om_reg : bm_reg;
            day_reg   <= cmd.sel_other ? od_reg : bd_reg;
        end
        else if (cmd.step_init)
        begin
            rd_reg   <= add_op ? RD_W'(day_reg) - RD_W'(1) + RD_W'(n_reg) : RD_W'(n_reg);
            m100_reg <= rem;
            c4_reg   <= quot[1:0];
        end
        else if (cmd.step && step_done)
        begin
            day_reg <= add_op ? DAY_W'(rd_reg + RD_W'(1)) : day_reg - DAY_W'(rd_reg);
        end
        else if (cmd.step && !step_ovf)
        begin
            if (add_op)
            begin
                rd_reg <= rd_reg - RD_W'(len_cur);
                if (month_reg == MON_W'(MONTHS))
                begin
                    month_reg <= MON_W'(1);
                    year_reg  <= year_reg + YR_W'(1);
                    if (m100_reg == REM_W'(CENTURY - 1))
                    begin
                        m100_reg <= '0;
                        c4_reg   <= c4_reg + 2'd1;
                    end
                    else
                    begin
                        m100_reg <= m100_reg + REM_W'(1);
                    end
                end
                else
                begin
                    month_reg <= month_reg + MON_W'(1);
                end
            end
            else
            begin
                rd_reg <= rd_reg - RD_W'(day_reg);
                if (month_reg == MON_W'(1))
                begin
                    month_reg <= MON_W'(MONTHS);
                    day_reg   <= days_in_month(1'b0, MON_W'(MONTHS));
                    year_reg  <= year_reg - YR_W'(1);
                    if (m100_reg == '0)
                    begin
                        m100_reg <= REM_W'(CENTURY - 1);
                        c4_reg   <= c4_reg - 2'd1;
                    end
                    else
                    begin
                        m100_reg <= m100_reg - REM_W'(1);
                    end
                end
                else
                begin
                    month_reg <= month_reg - MON_W'(1);
                    day_reg   <= len_prev;
                end
            end
        end
    end

    // Store serial day numbers of both dates
    always_ff @(posedge clk)
    begin
        if (cmd.ser_year)
        begin
            sery_reg <= ser_y;
        end
        if (cmd.ser_day && !cmd.sel_other)
        begin
            ser_a_reg <= ser_d;
        end
        if (cmd.ser_day && cmd.sel_other)
        begin
            ser_b_reg <= ser_d;
        end
    end

    // Capture the result transaction
    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            ry_reg      <= (fin_ok && date_op) ? YEAR_FW'(year_reg) : '0;
            rm_reg      <= (fin_ok && date_op) ? month_reg : '0;
            rday_reg    <= (fin_ok && date_op) ? day_reg : '0;
            between_reg <= (fin_ok && (op_reg == OP_DIFF)) ?
                           (sat ? '1 : CNT_W'(diff)) : '0;
            ord_reg     <= (fin_ok && (op_reg == OP_CMP)) ? fin_ord : ORD_BEFORE;
            err_reg     <= fin_err;
        end
    end

    always_comb
    begin
        sts.div_busy  = div_busy;
        sts.date_ok   = date_ok;
        sts.date_op   = date_op;
        sts.step_done = step_done;
        sts.step_ovf  = step_ovf;
    end

    assign result_year  = ry_reg;
    assign result_month = rm_reg;
    assign result_day   = rday_reg;
    assign days_between = between_reg;
    assign order        = ord_reg;
    assign error_code   = err_reg;

endmodule

// ----- design/gda_ctrl.sv -----
// Controller state machine of the date calculator: sequences the datapath and
// runs both handshakes. Depends on gda_pkg.
module gda_ctrl
    import gda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  gda_sts_t sts,
    output gda_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SERY  = 3'd4;
    localparam logic [2:0] S_SERD  = 3'd5;
    localparam logic [2:0] S_STEP  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic              phase_reg, phase_next;
    logic [CODE_W-1:0] err_reg, err_next;
    logic              ovalid_reg, ovalid_next;
    logic              out_free;

    assign out_free = !ovalid_reg || !out_stall;

    // Sequence one transaction
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        err_next      = err_reg;
        ovalid_next   = ovalid_reg && out_stall;
        cmd           = '0;
        cmd.sel_other = phase_reg;
        cmd.err       = err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = 1'b0;
                    err_next   = ERR_OK;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!sts.date_ok)
                begin
                    err_next   = ERR_DATE;
                    state_next = S_FIN;
                end
                else if (sts.date_op)
                begin
                    cmd.step_init = 1'b1;
                    state_next    = S_STEP;
                end
                else
                begin
                    state_next = S_SERY;
                end
            end
            S_SERY:
            begin
                cmd.ser_year = 1'b1;
                state_next   = S_SERD;
            end
            S_SERD:
            begin
                cmd.ser_day = 1'b1;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    state_next = S_START;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (sts.step_done)
                begin
                    state_next = S_FIN;
                end
                else if (sts.step_ovf)
                begin
                    err_next   = ERR_RANGE;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.fin     = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= 1'b0;
            err_reg    <= ERR_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ovalid_reg;

endmodule

// ----- design/gregorian_date_arith.sv -----
// Top level of the proleptic Gregorian date calculator.
// Depends on gda_pkg, gda_ctrl, gda_dp and gda_div.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction: an operation,
//   a base date, a day count and an other date. Output channel (out_valid /
//   out_stall) returns one result transaction for each input transaction.
//   The block works on one transaction at a time; in_stall is low only while
//   the controller is idle.
//   From acceptance, add and subtract start the divider, check the date and
//   then walk one calendar month per step until the day count is used up or
//   the year range is left. Difference and compare start the divider, check
//   the date and build a serial day number for the base date, then for the
//   other date; an invalid date ends the transaction earlier. The controller
//   returns to idle when the result is issued and accepts the next one there.
//   The result waits in an output register; a new transaction is accepted
//   while it waits. If the receiver stalls, out_valid and the result hold and
//   a finished transaction waits in the controller until the register frees.
//   Reset clears the controller and the output valid; no clearing pass.
module gregorian_date_arith
    import gda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [YEAR_FW-1:0] base_year,
    input  logic [MON_W-1:0]   base_month,
    input  logic [DAY_W-1:0]   base_day,
    input  logic [CNT_W-1:0]   day_count,
    input  logic [YEAR_FW-1:0] other_year,
    input  logic [MON_W-1:0]   other_month,
    input  logic [DAY_W-1:0]   other_day,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [YEAR_FW-1:0] result_year,
    output logic [MON_W-1:0]   result_month,
    output logic [DAY_W-1:0]   result_day,
    output logic [CNT_W-1:0]   days_between,
    output logic [CODE_W-1:0]  order,
    output logic [CODE_W-1:0]  error_code
);

    gda_cmd_t cmd;
    gda_sts_t sts;

    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    gda_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .base_year    (base_year),
        .base_month   (base_month),
        .base_day     (base_day),
        .day_count    (day_count),
        .other_year   (other_year),
        .other_month  (other_month),
        .other_day    (other_day),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .days_between (days_between),
        .order        (order),
        .error_code   (error_code)
    );

endmodule
